// ===== hdl/llm_pkg.sv =====
// ============================================================================
// llm_pkg
// Shared types and constants for the LED level meter with peak hold.
// ============================================================================
`default_nettype none

package llm_pkg;

  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned NUM_LEDS = 8;
  localparam int unsigned TH_W = 40;
  localparam int unsigned FADE_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // display modes
  localparam logic [MODE_W-1:0] MODE_BAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PEAK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TEST = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TH_LOWER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TH_UPPER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME  = 2'd3;

  // reset values: 19,30,49,79 and 126,201,322,573
  localparam logic [TH_W-1:0]    TH_LOWER_RST   = 40'd84877015059;
  localparam logic [TH_W-1:0]    TH_UPPER_RST   = 40'd615591912574;
  localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RST = 10'd910;
  localparam logic [FADE_W-1:0]  FADE_TIME_RST  = 8'd50;

  localparam logic [NUM_LEDS-1:0] TOP_LED = 8'h80;

  typedef struct packed {
    logic [TH_W-1:0]    th_upper;
    logic [TH_W-1:0]    th_lower;
    logic [LEVEL_W-1:0] clip_level;
    logic [FADE_W-1:0]  fade_time;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [NUM_LEDS-1:0] peak;
    logic [FADE_W-1:0]   fade_cnt;
    logic                clip;
  } meter_state_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] leds;
    logic [MODE_W-1:0]   mode;
    logic                clip;
  } result_t;

endpackage : llm_pkg

`default_nettype wire

// ===== hdl/led_level_meter_peak_hold.sv =====
// ============================================================================
// led_level_meter_peak_hold
// Eight-LED level meter with bar, peak hold, dot and blank test modes, clip
// latch and timed peak decay. One result per sample.
// ============================================================================
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  in_sample[9:0], in_button_press
//  out      out  out_valid/out_stall out_led_pattern[7:0], out_active_mode[1:0],
//                                   out_clip_flag
//  cfg      in   cfg_wr_en          cfg_index[1:0], cfg_wdata[39:0]
//
//  One sample per cycle sustained while out_stall is low; a transfer passes
//  through the input register, then is evaluated into the result register.
//  Meter state updates as a sample moves into the result register.
//  in_stall rises only when the input register is full and the result
//  register is held by out_stall.
//  Synchronous active-low reset clears mode, peak, fade count, clip and
//  restores the default thresholds, clip level and fade time.
// ============================================================================
`default_nettype none

module led_level_meter_peak_hold
  import llm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LEVEL_W-1:0]   in_sample,
  input  wire logic                 in_button_press,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [NUM_LEDS-1:0]       out_led_pattern,
  output logic [MODE_W-1:0]         out_active_mode,
  output logic                      out_clip_flag,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TH_W-1:0]      cfg_wdata
);

  cfg_t                cfg_r;
  meter_state_t        st_r;
  meter_state_t        st_nxt;
  result_t             res_nxt;
  result_t             res_r;
  logic                s1_valid_r;
  logic [LEVEL_W-1:0]  s1_sample_r;
  logic                s1_press_r;
  logic                out_valid_r;
  logic                out_free;
  logic                advance;
  logic                in_xfer;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.th_lower   <= TH_LOWER_RST;
      cfg_r.th_upper   <= TH_UPPER_RST;
      cfg_r.clip_level <= CLIP_LEVEL_RST;
      cfg_r.fade_time  <= FADE_TIME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TH_LOWER:   cfg_r.th_lower   <= cfg_wdata;
        CFG_TH_UPPER:   cfg_r.th_upper   <= cfg_wdata;
        CFG_CLIP_LEVEL: cfg_r.clip_level <= cfg_wdata[LEVEL_W-1:0];
        CFG_FADE_TIME:  cfg_r.fade_time  <= cfg_wdata[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample;
      s1_press_r  <= in_button_press;
    end
  end

  llm_eval u_eval (
    .cfg    (cfg_r),
    .st     (st_r),
    .sample (s1_sample_r),
    .press  (s1_press_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = res_r.leds;
  assign out_active_mode = res_r.mode;
  assign out_clip_flag   = res_r.clip;

  // clip can only be latched in peak hold mode, and a press then clears it
  a_clip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.clip |-> st_r.mode == MODE_PEAK)
    else $error("clip latched outside peak hold mode");

  a_clip_peak: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.clip |-> st_r.peak[NUM_LEDS-1])
    else $error("clip latched without top peak LED");

  a_test_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.mode == MODE_TEST) |-> res_r.leds == '0)
    else $error("test mode pattern not blank");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("meter state changed without a sample");

endmodule : led_level_meter_peak_hold

`default_nettype wire

// ===== hdl/llm_eval.sv =====
// ============================================================================
// llm_eval
// Combinational evaluation of one sample: button handling, threshold
// compare, bar/dot pattern, peak hold rise, clip latch and decay.
// ============================================================================
`default_nettype none

module llm_eval
  import llm_pkg::*;
(
  input  wire cfg_t               cfg,
  input  wire meter_state_t       st,
  input  wire logic [LEVEL_W-1:0] sample,
  input  wire logic               press,
  output meter_state_t            st_nxt,
  output result_t                 res
);

  logic [2*TH_W-1:0]   th_all;
  logic [NUM_LEDS-1:0] gt;
  logic [NUM_LEDS-1:0] bar;
  logic [NUM_LEDS-1:0] bar_top;
  logic [NUM_LEDS-1:0] dot;
  meter_state_t        st_b;
  meter_state_t        st_p;

  assign th_all = {cfg.th_upper, cfg.th_lower};

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      gt[i] = sample > th_all[i*LEVEL_W +: LEVEL_W];
    end
    // bar stops at the first threshold not exceeded
    bar[0] = gt[0];
    for (int i = 1; i < NUM_LEDS; i++) begin
      bar[i] = bar[i-1] & gt[i];
    end
    // dot: highest exceeded threshold only
    dot = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (gt[i]) begin
        dot = '0;
        dot[i] = 1'b1;
      end
    end
  end

  // bar is a contiguous run from bit 0, so this isolates its top LED
  assign bar_top = bar ^ (bar >> 1);

  always_comb begin
    st_b = st;
    if (press) begin
      if (st.clip) begin
        st_b.clip = 1'b0;
        st_b.peak = '0;
      end else begin
        st_b.mode = st.mode + 2'd1;
      end
    end

    st_p = st_b;
    if (st_b.mode == MODE_PEAK) begin
      if (bar != '0 && st_b.peak < bar_top) begin
        st_p.peak     = bar_top;
        st_p.fade_cnt = cfg.fade_time;
      end
      if (bar[NUM_LEDS-1] && sample > cfg.clip_level) begin
        st_p.clip = 1'b1;
      end
      if (st_p.clip) begin
        st_p.peak = st_p.peak | TOP_LED;
      end else if (st_p.fade_cnt != '0) begin
        st_p.fade_cnt = st_p.fade_cnt - 8'd1;
      end else begin
        st_p.peak     = st_p.peak >> 1;
        st_p.fade_cnt = cfg.fade_time;
      end
    end
    st_nxt = st_p;
  end

  always_comb begin
    res.mode = st_p.mode;
    res.clip = st_p.clip;
    case (st_p.mode)
      MODE_BAR:  res.leds = bar;
      MODE_PEAK: res.leds = bar | st_p.peak;
      MODE_DOT:  res.leds = dot;
      MODE_TEST: res.leds = '0;
      default:   res.leds = '0;
    endcase
  end

endmodule : llm_eval

`default_nettype wire

// ===== sim/led_level_meter_peak_hold_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// led_level_meter_peak_hold_tb
// Self-checking bench for the LED level meter: a scoreboard class predicts
// the LED pattern, mode and clip flag for every sample transfer and checks
// each result transfer in order. Stimulus runs directed cases at reset
// settings, then random envelopes under several threshold, clip and fade
// settings, with bursty input traffic and random output stalls.
// ============================================================================

import llm_pkg::*;

class meter_scoreboard;
  logic [TH_W-1:0]     th_lower;
  logic [TH_W-1:0]     th_upper;
  logic [LEVEL_W-1:0]  clip_lvl;
  logic [FADE_W-1:0]   fade_len;
  logic [MODE_W-1:0]   mode;
  logic [NUM_LEDS-1:0] peak;
  logic [FADE_W-1:0]   fade_cnt;
  logic                clip;
  result_t             expected_displays[$];
  int                  errors;

  function new();
    th_lower = TH_LOWER_RST;
    th_upper = TH_UPPER_RST;
    clip_lvl = CLIP_LEVEL_RST;
    fade_len = FADE_TIME_RST;
    mode     = MODE_BAR;
    peak     = '0;
    fade_cnt = '0;
    clip     = 1'b0;
    errors   = 0;
  endfunction

  function logic [LEVEL_W-1:0] threshold(int i);
    logic [TH_W-1:0] word;
    word = (i < 4) ? th_lower : th_upper;
    return word[(i % 4) * LEVEL_W +: LEVEL_W];
  endfunction

  function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [TH_W-1:0] data);
    case (idx)
      CFG_TH_LOWER:   th_lower = data;
      CFG_TH_UPPER:   th_upper = data;
      CFG_CLIP_LEVEL: clip_lvl = data[LEVEL_W-1:0];
      CFG_FADE_TIME:  fade_len = data[FADE_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample transfer -> one expected display
  function void note_sample(logic [LEVEL_W-1:0] smp, logic press);
    logic [NUM_LEDS-1:0] bar;
    logic [NUM_LEDS-1:0] leds;
    result_t r;
    bar  = '0;
    leds = '0;
    if (press) begin
      if (clip) begin
        clip = 1'b0;
        peak = '0;
      end else begin
        mode = mode + 1'b1;
      end
    end
    if (mode == MODE_BAR || mode == MODE_PEAK) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (smp <= threshold(i)) break;
        bar[i] = 1'b1;
        if (mode == MODE_PEAK && peak < (8'd1 << i)) begin
          peak     = 8'd1 << i;
          fade_cnt = fade_len;
        end
      end
      leds = bar;
      if (mode == MODE_PEAK) begin
        if ((bar & TOP_LED) != 0 && smp > clip_lvl) clip = 1'b1;
        if (clip) begin
          peak = peak | TOP_LED;
        end else if (fade_cnt != 0) begin
          fade_cnt = fade_cnt - 1'b1;
        end else begin
          peak     = peak >> 1;
          fade_cnt = fade_len;
        end
        leds = leds | peak;
      end
    end else if (mode == MODE_DOT) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (smp > threshold(i)) leds = 8'd1 << i;
      end
    end
    r.leds = leds;
    r.mode = mode;
    r.clip = clip;
    expected_displays.push_back(r);
  endfunction

  function void check_result(logic [NUM_LEDS-1:0] leds, logic [MODE_W-1:0] md,
                             logic clp);
    result_t e;
    if (expected_displays.size() == 0) begin
      $error("result transfer with no display expected");
      errors++;
      return;
    end
    e = expected_displays.pop_front();
    if (leds !== e.leds) begin
      $error("led_pattern: expected %h, got %h", e.leds, leds);
      errors++;
    end
    if (md !== e.mode) begin
      $error("active_mode: expected %0d, got %0d", e.mode, md);
      errors++;
    end
    if (clp !== e.clip) begin
      $error("clip_flag: expected %0d, got %0d", e.clip, clp);
      errors++;
    end
  endfunction

  function int pending();
    return expected_displays.size();
  endfunction
endclass

module led_level_meter_peak_hold_tb;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_sample = '0;
  logic                 in_button_press = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [NUM_LEDS-1:0]  out_led_pattern;
  logic [MODE_W-1:0]    out_active_mode;
  logic                 out_clip_flag;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TH_W-1:0]      cfg_wdata = '0;

  meter_scoreboard sb = new();

  int stall_pct = 30;     // receiver stall odds per run, percent
  int max_gap = 4;        // longest sender gap between bursts, cycles
  int burst_left = 0;
  int stall_left = 0;

  led_level_meter_peak_hold DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_button_press (in_button_press),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_pattern (out_led_pattern),
    .out_active_mode (out_active_mode),
    .out_clip_flag   (out_clip_flag),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: stall in runs of random length
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_left = $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_led_pattern, out_active_mode, out_clip_flag);
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_sample(input logic [LEVEL_W-1:0] smp, input logic press);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_sample       <= smp;
    in_button_press <= press;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(smp, press);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TH_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.apply_cfg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [TH_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TH_W-1:0];
  endfunction

  // envelope-like samples: quiet stretches let the peak decay, loud ones clip
  task automatic run_random(input int n);
    int kind;
    int seg_left;
    int v;
    logic press;
    kind = 0;
    seg_left = 0;
    for (int k = 0; k < n; k++) begin
      if (seg_left == 0) begin
        kind = $urandom_range(0, 3);
        seg_left = $urandom_range(2, 30);
      end
      seg_left--;
      case (kind)
        0: v = $urandom_range(0, 40);
        1: v = $urandom_range(0, 1023);
        2: v = $urandom_range(800, 1023);
        default: begin
          v = sb.threshold($urandom_range(0, 7)) + $urandom_range(0, 2) - 1;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end
      endcase
      if (sb.mode == MODE_PEAK)
        press = ($urandom_range(0, 29) == 0);
      else
        press = ($urandom_range(0, 11) == 0);
      send_sample(v[LEVEL_W-1:0], press);
    end
  endtask

  initial begin
    int t;
    logic [TH_W-1:0] packed_th;
    int guard;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset thresholds 19,30,49,79,126,201,322,573
    send_sample(10'd0,    1'b0);
    send_sample(10'd19,   1'b0);  // equal to threshold: strict compare
    send_sample(10'd20,   1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd573,  1'b0);
    send_sample(10'd0,    1'b1);  // peak hold mode, empty peak decays
    send_sample(10'd200,  1'b0);  // peak rises to LED 4
    send_sample(10'd0,    1'b0);
    send_sample(10'd911,  1'b0);  // above clip level
    send_sample(10'd0,    1'b0);
    send_sample(10'd0,    1'b1);  // press clears clip, mode stays
    send_sample(10'd910,  1'b0);  // at clip level: no clip
    send_sample(10'd1023, 1'b0);
    send_sample(10'd5,    1'b1);
    send_sample(10'd0,    1'b1);  // dot mode
    send_sample(10'd80,   1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0,    1'b1);  // test mode: blank
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b1);  // wraps to bar mode
    send_sample(10'd0,    1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd512,  1'b0);
    run_random(90);
    drain();

    // low extremes: everything above zero lights and clips, instant decay
    stall_pct = 0;
    max_gap = 0;
    write_reg(CFG_TH_LOWER, '0);
    write_reg(CFG_TH_UPPER, '0);
    write_reg(CFG_CLIP_LEVEL, '0);
    write_reg(CFG_FADE_TIME, '0);
    run_random(50);
    drain();

    // high extremes: nothing can light
    stall_pct = 50;
    max_gap = 6;
    write_reg(CFG_TH_LOWER, {TH_W{1'b1}});
    write_reg(CFG_TH_UPPER, {TH_W{1'b1}});
    write_reg(CFG_CLIP_LEVEL, {TH_W{1'b1}});
    write_reg(CFG_FADE_TIME, {TH_W{1'b1}});
    run_random(40);
    drain();

    // unordered thresholds, upper write bits set
    stall_pct = 25;
    max_gap = 3;
    write_reg(CFG_TH_LOWER, rand40());
    write_reg(CFG_TH_UPPER, rand40());
    write_reg(CFG_CLIP_LEVEL, rand40());
    write_reg(CFG_FADE_TIME, TH_W'($urandom_range(1, 4)));
    run_random(100);
    drain();

    // ascending thresholds, short fade
    stall_pct = 40;
    max_gap = 2;
    t = 0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      t += $urandom_range(1, 120);
      if (t > 1023) t = 1023;
      if (i < 4) packed_th[i * LEVEL_W +: LEVEL_W] = t[LEVEL_W-1:0];
      if (i == 3) write_reg(CFG_TH_LOWER, packed_th);
      if (i >= 4) packed_th[(i - 4) * LEVEL_W +: LEVEL_W] = t[LEVEL_W-1:0];
    end
    write_reg(CFG_TH_UPPER, packed_th);
    write_reg(CFG_CLIP_LEVEL, TH_W'($urandom_range(t, 1023)));
    write_reg(CFG_FADE_TIME, TH_W'($urandom_range(2, 8)));
    run_random(100);
    drain();

    // back to the default scale with a quick fade
    stall_pct = 15;
    max_gap = 1;
    write_reg(CFG_TH_LOWER, TH_LOWER_RST);
    write_reg(CFG_TH_UPPER, TH_UPPER_RST);
    write_reg(CFG_CLIP_LEVEL, CLIP_LEVEL_RST);
    write_reg(CFG_FADE_TIME, TH_W'(3));
    run_random(70);

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (5) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected displays never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
